// ----- src/rah_pkg.sv -----
package rah_pkg;

  localparam int DEF_LOG_SLOTS  = 12;
  localparam int DEF_HASH_SHIFT = 3;

  localparam int KEY_W    = 64;
  localparam int HANDLE_W = 16;
  localparam int SLOT_W   = 12;
  localparam int CFG_W    = 4;
  localparam int ENTRY_W  = 1 + KEY_W + HANDLE_W;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd12;
  localparam logic [CFG_W-1:0] MIN_LOG   = 4'd2;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_SLOT,
    RES_HIT,
    RES_MISS,
    RES_FULL
  } rah_res_t;

  typedef struct packed {
    logic     accept;
    logic     rd_en;
    logic     probe_adv;
    logic     write_entry;
    logic     sweep_wr;
    logic     res_load;
    rah_res_t res_sel;
    logic     out_load;
  } rah_cmd_t;

  typedef struct packed {
    logic used;
    logic key_match;
    logic last_probe;
    logic sweep_last;
    logic out_free;
    logic req_insert;
  } rah_stat_t;

endpackage

// ----- src/rah_ctrl.sv -----
module rah_ctrl import rah_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [1:0] req_type,
  input  rah_stat_t stat,
  output rah_cmd_t  cmd
);

  localparam logic [2:0] S_SWEEP_RST = 3'd0;
  localparam logic [2:0] S_IDLE      = 3'd1;
  localparam logic [2:0] S_READ      = 3'd2;
  localparam logic [2:0] S_CHECK     = 3'd3;
  localparam logic [2:0] S_SWEEP_CLR = 3'd4;
  localparam logic [2:0] S_DONE      = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP_RST;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res_sel = RES_ZERO;
    in_ready   = 1'b0;
    unique case (state)
      S_SWEEP_RST: begin
        cmd.sweep_wr = 1'b1;
        if (stat.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (req_type)
            REQ_CLEAR: state_next = S_SWEEP_CLR;
            REQ_INSERT, REQ_LOOKUP: state_next = S_READ;
            default: begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_ZERO;
              state_next   = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.req_insert) begin
          if (!stat.used) begin
            cmd.write_entry = 1'b1;
            cmd.res_load    = 1'b1;
            cmd.res_sel     = RES_SLOT;
            state_next      = S_DONE;
          end else if (stat.last_probe) begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_FULL;
            state_next   = S_DONE;
          end else begin
            cmd.probe_adv = 1'b1;
          end
        end else begin
          if (!stat.used) begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_MISS;
            state_next   = S_DONE;
          end else if (stat.key_match) begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_HIT;
            state_next   = S_DONE;
          end else if (stat.last_probe) begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_MISS;
            state_next   = S_DONE;
          end else begin
            cmd.probe_adv = 1'b1;
          end
        end
      end
      S_SWEEP_CLR: begin
        cmd.sweep_wr = 1'b1;
        if (stat.sweep_last) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_ZERO;
          state_next   = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/rah_dpath.sv -----
module rah_dpath import rah_pkg::*; #(
  parameter int LOG_SLOTS  = DEF_LOG_SLOTS,
  parameter int HASH_SHIFT = DEF_HASH_SHIFT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data,
  input  logic [1:0]          req_type,
  input  logic [KEY_W-1:0]    key_address,
  input  logic [HANDLE_W-1:0] handle_in,
  input  rah_cmd_t            cmd,
  output rah_stat_t           stat,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [1:0]          status,
  output logic [HANDLE_W-1:0] handle_out,
  output logic [SLOT_W-1:0]   slot_index
);

  localparam int SLOTS = 1 << LOG_SLOTS;
  localparam logic [4:0] LogMax = 5'(LOG_SLOTS);

  logic [CFG_W-1:0]    cfg_log;
  logic [1:0]          req_q;
  logic [KEY_W-1:0]    key_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [LOG_SLOTS-1:0] h;
  logic [LOG_SLOTS-1:0] n;
  logic [LOG_SLOTS-1:0] sweep_cnt;
  logic [ENTRY_W-1:0]  rd_q;
  logic [1:0]          res_status;
  logic [HANDLE_W-1:0] res_handle;
  logic [LOG_SLOTS-1:0] res_slot;

  logic [ENTRY_W-1:0]  mem [SLOTS];

  logic [4:0]           k_act;
  logic [4:0]           mask_sh;
  logic [LOG_SLOTS-1:0] mask;
  logic [KEY_W-1:0]     key_sh;
  logic [LOG_SLOTS-1:0] hash;
  logic [LOG_SLOTS-1:0] h_inc;
  logic [LOG_SLOTS-1:0] rd_addr;
  logic                 wr_en;
  logic [LOG_SLOTS-1:0] wr_addr;
  logic [ENTRY_W-1:0]   wr_data;
  logic [LOG_SLOTS+SLOT_W-1:0] slot_wide;

  always_comb begin
    if (cfg_log < MIN_LOG) begin
      k_act = 5'(MIN_LOG);
    end else if (5'(cfg_log) > LogMax) begin
      k_act = LogMax;
    end else begin
      k_act = 5'(cfg_log);
    end
  end

  assign mask_sh = LogMax - k_act;
  assign mask    = {LOG_SLOTS{1'b1}} >> mask_sh;
  assign key_sh  = key_address >> HASH_SHIFT;
  assign hash    = key_sh[LOG_SLOTS-1:0] & mask;
  assign h_inc   = (h + LOG_SLOTS'(1)) & mask;
  assign rd_addr = cmd.probe_adv ? h_inc : h;

  always_comb begin
    wr_en   = cmd.sweep_wr | cmd.write_entry;
    wr_addr = cmd.sweep_wr ? sweep_cnt : h;
    wr_data = cmd.sweep_wr ? '0 : {1'b1, key_q, handle_q};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en || cmd.probe_adv) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_log   <= CFG_RESET;
      sweep_cnt <= '0;
    end else begin
      if (cfg_wr_en) begin
        cfg_log <= cfg_wr_data;
      end
      if (cmd.sweep_wr) begin
        sweep_cnt <= sweep_cnt + LOG_SLOTS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q    <= req_type;
      key_q    <= key_address;
      handle_q <= handle_in;
      h        <= hash;
      n        <= '0;
    end else if (cmd.probe_adv) begin
      h <= h_inc;
      n <= n + LOG_SLOTS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_sel)
        RES_SLOT: begin
          res_status <= STATUS_OK;
          res_handle <= '0;
          res_slot   <= h;
        end
        RES_HIT: begin
          res_status <= STATUS_OK;
          res_handle <= rd_q[HANDLE_W-1:0];
          res_slot   <= h;
        end
        RES_MISS: begin
          res_status <= STATUS_MISS;
          res_handle <= '0;
          res_slot   <= '0;
        end
        RES_FULL: begin
          res_status <= STATUS_FULL;
          res_handle <= '0;
          res_slot   <= '0;
        end
        default: begin
          res_status <= STATUS_OK;
          res_handle <= '0;
          res_slot   <= '0;
        end
      endcase
    end
  end

  assign slot_wide = {{SLOT_W{1'b0}}, res_slot};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status     <= res_status;
      handle_out <= res_handle;
      slot_index <= slot_wide[SLOT_W-1:0];
    end
  end

  always_comb begin
    stat.used       = rd_q[ENTRY_W-1];
    stat.key_match  = (rd_q[HANDLE_W +: KEY_W] == key_q);
    stat.last_probe = (n == mask);
    stat.sweep_last = &sweep_cnt;
    stat.out_free   = !out_valid || out_ready;
    stat.req_insert = (req_q == REQ_INSERT);
  end

endmodule

// ----- src/return_address_hash_table_unit.sv -----
// Hash table of return addresses with linear probing over 2^LOG_SLOTS slots,
// of which 2^cfg_log (clamped to 2..LOG_SLOTS) are probed, starting
// at the low bits of (key >> HASH_SHIFT). Storage is one single-port-read,
// single-port-write memory, and each probe of an insert or lookup costs one
// read; a full or exhausted probe reports status 2 or 1 after visiting every
// active slot. Clear sweeps the whole memory one entry a cycle. After reset
// the same sweep runs with in_ready low; config writes are taken during it.
// A finished result sits in an output register, and the block waits only if
// the previous result has not yet been taken.
module return_address_hash_table_unit import rah_pkg::*; #(
  parameter int LOG_SLOTS  = DEF_LOG_SLOTS,
  parameter int HASH_SHIFT = DEF_HASH_SHIFT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          req_type,
  input  logic [KEY_W-1:0]    key_address,
  input  logic [HANDLE_W-1:0] handle_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          status,
  output logic [HANDLE_W-1:0] handle_out,
  output logic [SLOT_W-1:0]   slot_index
);

  rah_cmd_t  cmd;
  rah_stat_t stat;

  rah_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .stat     (stat),
    .cmd      (cmd)
  );

  rah_dpath #(
    .LOG_SLOTS  (LOG_SLOTS),
    .HASH_SHIFT (HASH_SHIFT)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_type    (req_type),
    .key_address (key_address),
    .handle_in   (handle_in),
    .cmd         (cmd),
    .stat        (stat),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .status      (status),
    .handle_out  (handle_out),
    .slot_index  (slot_index)
  );

endmodule

// ----- src/rah_checker.sv -----
module rah_checker import rah_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                cfg_wr_en,
  input logic [CFG_W-1:0]    cfg_wr_data,
  input logic                in_valid,
  input logic                in_ready,
  input logic [1:0]          req_type,
  input logic [KEY_W-1:0]    key_address,
  input logic [HANDLE_W-1:0] handle_in,
  input logic                out_valid,
  input logic                out_ready,
  input logic [1:0]          status,
  input logic [HANDLE_W-1:0] handle_out,
  input logic [SLOT_W-1:0]   slot_index
);

  // one transaction in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a transaction is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(status) && $stable(handle_out) && $stable(slot_index)))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == STATUS_OK || status == STATUS_MISS || status == STATUS_FULL))
    else $error("bad status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STATUS_OK) |-> (handle_out == '0 && slot_index == '0))
    else $error("failed transaction carries nonzero fields");

endmodule

bind return_address_hash_table_unit rah_checker u_rah_checker (.*);

// ----- bench/return_address_hash_table_unit_tb.sv -----
`timescale 1ns / 1ps

module return_address_hash_table_unit_tb;
  import rah_pkg::*;

  localparam int STORE_SLOTS = 1 << DEF_LOG_SLOTS;
  localparam int MAX_GAP = 18;
  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_SHOWN = 10;
  localparam int PHASE_ITEMS = 75;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]          status;
    logic [HANDLE_W-1:0] handle;
    logic [SLOT_W-1:0]   slot;
  } table_result_t;

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic [CFG_W-1:0]    cfg_wr_data;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          req_type;
  logic [KEY_W-1:0]    key_address;
  logic [HANDLE_W-1:0] handle_in;
  logic                out_valid;
  logic                out_ready;
  logic [1:0]          status;
  logic [HANDLE_W-1:0] handle_out;
  logic [SLOT_W-1:0]   slot_index;

  // shadow copy of the table
  bit                  slot_busy [STORE_SLOTS];
  logic [KEY_W-1:0]    slot_addr [STORE_SLOTS];
  logic [HANDLE_W-1:0] slot_hnd [STORE_SLOTS];
  logic [CFG_W-1:0]    size_log2 = CFG_RESET;

  table_result_t       pending_results [$];
  table_result_t       oldest_result;
  logic [KEY_W-1:0]    live_keys [$];
  int                  errors = 0;
  int                  idle_cycles = 0;
  bit                  steady = 1'b0;

  return_address_hash_table_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .key_address (key_address),
    .handle_in   (handle_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .handle_out  (handle_out),
    .slot_index  (slot_index)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic table_result_t table_apply(logic [1:0] req, logic [KEY_W-1:0] addr,
                                                logic [HANDLE_W-1:0] hnd);
    table_result_t r;
    int k;
    int mask;
    int h;
    int n;
    r = '0;
    k = size_log2;
    if (k < MIN_LOG) k = MIN_LOG;
    if (k > DEF_LOG_SLOTS) k = DEF_LOG_SLOTS;
    mask = (1 << k) - 1;
    h = int'(addr >> DEF_HASH_SHIFT) & mask;
    case (req)
      REQ_CLEAR: begin
        foreach (slot_busy[i]) slot_busy[i] = 1'b0;
      end
      REQ_INSERT: begin
        r.status = STATUS_FULL;
        for (n = 0; n <= mask; n++) begin
          if (!slot_busy[h]) begin
            slot_busy[h] = 1'b1;
            slot_addr[h] = addr;
            slot_hnd[h] = hnd;
            r.status = STATUS_OK;
            r.slot = SLOT_W'(h);
            break;
          end
          h = (h + 1) & mask;
        end
      end
      REQ_LOOKUP: begin
        r.status = STATUS_MISS;
        for (n = 0; n <= mask; n++) begin
          if (!slot_busy[h]) break;
          if (slot_addr[h] == addr) begin
            r.status = STATUS_OK;
            r.handle = slot_hnd[h];
            r.slot = SLOT_W'(h);
            break;
          end
          h = (h + 1) & mask;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void note_mismatch(string field, longint unsigned want,
                                        longint unsigned got);
    errors++;
    if (errors <= MAX_SHOWN)
      $display("mismatch on %s: expected %0h, got %0h", field, want, got);
  endfunction

  task automatic send_request(logic [1:0] req, logic [KEY_W-1:0] addr,
                              logic [HANDLE_W-1:0] hnd);
    int gap;
    table_result_t r;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    key_address <= addr;
    handle_in <= hnd;
    do @(posedge clk); while (!in_ready);
    r = table_apply(req, addr, hnd);
    pending_results.push_back(r);
    if (req == REQ_CLEAR) live_keys.delete();
    else if (req == REQ_INSERT && r.status == STATUS_OK) live_keys.push_back(addr);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_size(logic [CFG_W-1:0] v);
    wait_drained();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    size_log2 = v;
  endtask

  task automatic test_empty_table();
    send_request(REQ_LOOKUP, '0, '0);
    send_request(REQ_UNUSED, '1, '1);
    send_request(REQ_INSERT, '1, '1);
    send_request(REQ_LOOKUP, '1, '0);
    send_request(REQ_INSERT, '0, '0);
    send_request(REQ_LOOKUP, '0, '1);
    send_request(REQ_CLEAR, '1, '1);
    send_request(REQ_LOOKUP, '1, '0);
  endtask

  // all five keys hash to slot 2 of a four-slot table; the fifth finds it full
  task automatic test_collisions();
    write_size(4'd1);
    send_request(REQ_INSERT, 64'h10, 16'h1111);
    send_request(REQ_INSERT, 64'h30, 16'h2222);
    send_request(REQ_INSERT, 64'h50, 16'h3333);
    send_request(REQ_INSERT, 64'h70, 16'h4444);
    send_request(REQ_INSERT, 64'h90, 16'h5555);
    send_request(REQ_LOOKUP, 64'h70, '0);
    send_request(REQ_LOOKUP, 64'h90, '0);
    write_size(4'd0);
    send_request(REQ_LOOKUP, 64'h50, '0);
  endtask

  task automatic test_duplicates();
    send_request(REQ_CLEAR, '0, '0);
    send_request(REQ_INSERT, 64'hAB00, 16'h0001);
    send_request(REQ_INSERT, 64'hAB00, 16'h0002);
    send_request(REQ_LOOKUP, 64'hAB00, '0);
  endtask

  // an entry outside the shrunk range reappears when the table grows again
  task automatic test_resize();
    write_size(4'd15);
    send_request(REQ_INSERT, 64'h8000_0000_0000_1008, 16'hBEEF);
    write_size(4'd3);
    send_request(REQ_LOOKUP, 64'h8000_0000_0000_1008, '0);
    write_size(4'd13);
    send_request(REQ_LOOKUP, 64'h8000_0000_0000_1008, '0);
  endtask

  task automatic random_request();
    int pick;
    logic [KEY_W-1:0] addr;
    logic [KEY_W-1:0] known;
    logic [HANDLE_W-1:0] hnd;
    pick = $urandom_range(0, 99);
    addr = {$urandom, $urandom};
    hnd = HANDLE_W'($urandom);
    known = live_keys.size() != 0 ? live_keys[$urandom_range(0, live_keys.size() - 1)] : addr;
    if (pick < 40) send_request(REQ_INSERT, addr, hnd);
    else if (pick < 70) send_request(REQ_LOOKUP, known, hnd);
    else if (pick < 85) send_request(REQ_LOOKUP, addr, hnd);
    else if (pick < 94) send_request(REQ_INSERT, known, hnd);
    else if (pick < 98) send_request(REQ_UNUSED, addr, hnd);
    else send_request(REQ_CLEAR, addr, hnd);
  endtask

  task automatic test_random();
    logic [CFG_W-1:0] plan [20] = '{4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd12, 4'd9,
                                    4'd0, 4'd10, 4'd14, 4'd2, 4'd4, 4'd11, 4'd15, 4'd13,
                                    4'd1, 4'd3, 4'd5};
    foreach (plan[p]) begin
      write_size(plan[p]);
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 1) send_request(REQ_CLEAR, '0, '0);
      repeat (PHASE_ITEMS) random_request();
    end
    steady = 1'b0;
  endtask

  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = draw_gap();
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("transaction with nothing pending: status %0h handle %0h slot %0h",
                   status, handle_out, slot_index);
      end else begin
        oldest_result = pending_results.pop_front();
        if (status !== oldest_result.status)
          note_mismatch("status", oldest_result.status, status);
        if (handle_out !== oldest_result.handle)
          note_mismatch("handle_out", oldest_result.handle, handle_out);
        if (slot_index !== oldest_result.slot)
          note_mismatch("slot_index", oldest_result.slot, slot_index);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    req_type = REQ_CLEAR;
    key_address = '0;
    handle_in = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_collisions();
    test_duplicates();
    test_resize();
    test_random();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
